// File: hw/rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// shared widths, register indexes and types of the sobel gradient block
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int OCOL_W     = 10;
  localparam int MAG_W      = 8;
  localparam int IMG_W_W    = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // signed gradient: weighted sums reach 1020 either way
  localparam int GRAD_W     = 11;

  // queue between front and back
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  // queue entry width without its two column fields
  localparam int ENT_FIXED_W = 2 * GRAD_W + 1 + 3 + ROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST = 16'd480;

  // result kinds a pixel can cause, in emission order
  localparam int EMIT_PREV = 0;  // position one up and one left
  localparam int EMIT_EDGE = 1;  // right border of the row above
  localparam int EMIT_LAST = 2;  // own position on the last row

  typedef struct packed {
    logic [IMG_W_W-1:0] image_width;
    logic [ROW_W-1:0]   image_height;
  } geom_t;

endpackage

// File: hw/rtl/sgm_pixel_if.sv
// ----------------------------------------------------------------------------
// sgm_pixel_if
// pixel channel: valid/ready handshake with one grey pixel per request
// ----------------------------------------------------------------------------
interface sgm_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [sgm_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: hw/rtl/sgm_result_if.sv
// ----------------------------------------------------------------------------
// sgm_result_if
// result channel: position, gradient magnitude and end-of-burst flag
// ----------------------------------------------------------------------------
interface sgm_result_if;
  logic                       valid;
  logic                       ready;
  logic [sgm_pkg::ROW_W-1:0]  out_row;
  logic [sgm_pkg::OCOL_W-1:0] out_col;
  logic [sgm_pkg::MAG_W-1:0]  magnitude;
  logic                       run_last;

  modport source (output valid, output out_row, output out_col, output magnitude,
                  output run_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input magnitude,
                  input run_last, output ready);
endinterface

// File: hw/rtl/sgm_queue.sv
// ----------------------------------------------------------------------------
// sgm_queue
// small first-word-fall-through queue between the front and back parts
// ----------------------------------------------------------------------------
module sgm_queue #(
  parameter int Width = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           push_data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           pop_data_o,
  output logic                       not_empty_o,
  output logic [sgm_pkg::QCNT_W-1:0] free_o
);
  import sgm_pkg::*;

  logic [Width-1:0]  mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign not_empty_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign free_o      = QCNT_W'(QDEPTH) - cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/sgm_front.sv
// ----------------------------------------------------------------------------
// sgm_front
// pixel intake: raster counters, line memory, 3x3 window, gradients and
// classification of the results each pixel causes
// ----------------------------------------------------------------------------
module sgm_front #(
  parameter int MaxWidth = 1024
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  sgm_pkg::geom_t                                         geom_i,
  sgm_pixel_if.sink                                              pix_i,
  input  logic [sgm_pkg::QCNT_W-1:0]                             q_free_i,
  output logic                                                   push_o,
  output logic [sgm_pkg::ENT_FIXED_W+2*$clog2(MaxWidth)-1:0]     push_data_o
);
  import sgm_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int EffW = ($clog2(MaxWidth + 1) > IMG_W_W) ? $clog2(MaxWidth + 1) : IMG_W_W;
  localparam int SumW = PIX_W + 2;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     interior;
    logic [2:0]               emit;
    logic [ROW_W-1:0]         row;
    logic [ColW-1:0]          col;
    logic [ColW-1:0]          wlast;
  } entry_t;

  // line memory: upper byte is two rows up, lower byte one row up
  logic [2*PIX_W-1:0] line_mem [MaxWidth];
  logic [2*PIX_W-1:0] rd_q;

  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] nw    [3][3];

  logic [ColW-1:0]  col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_px_q;
  entry_t           s1_ent_q, s1_ent_d;
  entry_t           push_ent;

  logic [EffW-1:0]  w_cfg, eff_w, wlast, col_ext;
  logic [ROW_W-1:0] eff_h, hlast;
  logic             accept, row_end, last_row, row_ge1;
  logic [SumW-1:0]  s_right, s_left, s_bot, s_top;

  assign pix_i.ready = (q_free_i > QCNT_W'(s1_valid_q));
  assign accept      = pix_i.valid && pix_i.ready;

  // geometry, saturated into its legal range
  always_comb begin
    w_cfg = EffW'(geom_i.image_width);
    if (w_cfg < EffW'(3)) begin
      eff_w = EffW'(3);
    end else if (w_cfg > EffW'(MaxWidth)) begin
      eff_w = EffW'(MaxWidth);
    end else begin
      eff_w = w_cfg;
    end
    eff_h   = (geom_i.image_height < ROW_W'(3)) ? ROW_W'(3) : geom_i.image_height;
    wlast   = eff_w - 1'b1;
    hlast   = eff_h - 1'b1;
    col_ext = EffW'(col_q);
  end

  always_comb begin
    row_end  = (col_ext >= wlast);
    last_row = (row_q >= hlast);
    row_ge1  = (row_q != '0);

    s1_ent_d                 = '0;
    s1_ent_d.emit[EMIT_PREV] = row_ge1 && (col_q != '0);
    s1_ent_d.emit[EMIT_EDGE] = row_ge1 && row_end;
    s1_ent_d.emit[EMIT_LAST] = last_row;
    s1_ent_d.interior        = (row_q >= ROW_W'(2)) && (row_q <= hlast) &&
                               (col_ext >= EffW'(2)) && (col_ext <= wlast);
    s1_ent_d.row             = row_q;
    s1_ent_d.col             = col_q;
    s1_ent_d.wlast           = ColW'(wlast);

    if (row_end) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= line_mem[col_q];
      s1_px_q  <= pix_i.pixel;
      s1_ent_q <= s1_ent_d;
    end
    if (s1_valid_q) begin
      line_mem[s1_ent_q.col] <= {rd_q[PIX_W-1:0], s1_px_q};
    end
  end

  // window after the shift: oldest column drops, new column enters right
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win_q[i][1];
      nw[i][1] = win_q[i][2];
    end
    nw[0][2] = rd_q[2*PIX_W-1:PIX_W];
    nw[1][2] = rd_q[PIX_W-1:0];
    nw[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_valid_q) begin
      win_q <= nw;
    end
  end

  always_comb begin
    s_right = SumW'(nw[0][2]) + {1'b0, nw[1][2], 1'b0} + SumW'(nw[2][2]);
    s_left  = SumW'(nw[0][0]) + {1'b0, nw[1][0], 1'b0} + SumW'(nw[2][0]);
    s_bot   = SumW'(nw[2][0]) + {1'b0, nw[2][1], 1'b0} + SumW'(nw[2][2]);
    s_top   = SumW'(nw[0][0]) + {1'b0, nw[0][1], 1'b0} + SumW'(nw[0][2]);

    push_ent    = s1_ent_q;
    push_ent.gx = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
    push_ent.gy = $signed({1'b0, s_bot}) - $signed({1'b0, s_top});
  end

  // pixels that cause no result only update the window and the line memory
  assign push_o      = s1_valid_q && (s1_ent_q.emit != '0);
  assign push_data_o = push_ent;

endmodule

// File: hw/rtl/sgm_back.sv
// ----------------------------------------------------------------------------
// sgm_back
// result issue: takes one queued pixel at a time and sends its results,
// one per cycle while the sink is ready, through the output register
// ----------------------------------------------------------------------------
module sgm_back #(
  parameter int MaxWidth = 1024
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               q_not_empty_i,
  input  logic [sgm_pkg::ENT_FIXED_W+2*$clog2(MaxWidth)-1:0] q_data_i,
  output logic                                               pop_o,
  sgm_result_if.source                                       res_o
);
  import sgm_pkg::*;

  localparam int ColW = $clog2(MaxWidth);
  localparam int AbsW = GRAD_W - 1;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     interior;
    logic [2:0]               emit;
    logic [ROW_W-1:0]         row;
    logic [ColW-1:0]          col;
    logic [ColW-1:0]          wlast;
  } entry_t;

  entry_t     cur_q, q_ent;
  logic [2:0] pend_q, sel, remain;
  logic       out_free, load_out, cur_done;

  logic              out_valid_q;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [OCOL_W-1:0] out_col_q, out_col_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              last_q;

  logic [AbsW-1:0]   abs_gx, abs_gy;
  logic [GRAD_W-1:0] l1_sum;
  logic [ColW-1:0]   col_pick;
  logic [ColW+OCOL_W-1:0] col_wide;

  assign q_ent = entry_t'(q_data_i);

  assign out_free = !out_valid_q || res_o.ready;
  assign load_out = out_free && (pend_q != '0);

  always_comb begin
    sel = '0;
    priority if (pend_q[EMIT_PREV]) begin
      sel[EMIT_PREV] = 1'b1;
    end else if (pend_q[EMIT_EDGE]) begin
      sel[EMIT_EDGE] = 1'b1;
    end else if (pend_q[EMIT_LAST]) begin
      sel[EMIT_LAST] = 1'b1;
    end else begin
      sel = '0;
    end
    remain = pend_q & ~sel;
  end

  assign cur_done = (pend_q == '0) || (load_out && (remain == '0));
  assign pop_o    = cur_done && q_not_empty_i;

  // l1 gradient magnitude
  always_comb begin
    abs_gx = cur_q.gx[GRAD_W-1] ? AbsW'(-cur_q.gx) : AbsW'(cur_q.gx);
    abs_gy = cur_q.gy[GRAD_W-1] ? AbsW'(-cur_q.gy) : AbsW'(cur_q.gy);
    l1_sum = GRAD_W'(abs_gx) + GRAD_W'(abs_gy);
  end

  always_comb begin
    out_row_d = cur_q.row;
    col_pick  = cur_q.col;
    mag_d     = '0;
    priority if (sel[EMIT_PREV]) begin
      out_row_d = cur_q.row - 1'b1;
      col_pick  = cur_q.col - 1'b1;
      mag_d     = cur_q.interior ? l1_sum[GRAD_W-1:3] : '0;
    end else if (sel[EMIT_EDGE]) begin
      out_row_d = cur_q.row - 1'b1;
      col_pick  = cur_q.wlast;
    end else begin
      out_row_d = cur_q.row;
      col_pick  = cur_q.col;
    end
    col_wide  = {{OCOL_W{1'b0}}, col_pick};
    out_col_d = col_wide[OCOL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pend_q <= q_ent.emit;
      end else if (load_out) begin
        pend_q <= remain;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_ent;
    end
    if (load_out) begin
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      mag_q     <= mag_d;
      last_q    <= (remain == '0);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_row   = out_row_q;
  assign res_o.out_col   = out_col_q;
  assign res_o.magnitude = mag_q;
  assign res_o.run_last  = last_q;

endmodule

// File: hw/rtl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// streaming 3x3 sobel edge detector with l1 gradient magnitude
// ----------------------------------------------------------------------------
// Grey pixels enter in raster order, one per clock when the result side keeps
// up. Each pixel past the first row and column gives the result for position
// one row up and one column left, so the frame comes out one row and one
// column behind; row ends add the right border of the row above and the last
// row adds its own positions. Results leave through a single output register
// at one per clock while the sink is ready, and a four-entry queue between
// pixel front end and result issue absorbs bursts of two or three results at
// row ends before the pixel side stalls. A pixel's first result passes the
// stage-one, queue, current-entry and output registers. The two line stores
// share one dual-byte memory of MAX_WIDTH entries, read when a pixel is taken
// and written back the next cycle; it needs no clearing after reset. The user
// must write geometry registers only while idle; the block does not check.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sgm_pixel_if.sink                          pix_i,
  sgm_result_if.source                       res_o,
  input  logic                               cfg_we_i,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import sgm_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int EntW = ENT_FIXED_W + 2 * ColW;

  geom_t geom_q;

  logic              push, pop, q_not_empty;
  logic [EntW-1:0]   push_data, pop_data;
  logic [QCNT_W-1:0] q_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.image_width  <= IMAGE_WIDTH_RST;
      geom_q.image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  geom_q.image_width  <= cfg_wdata_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: geom_q.image_height <= cfg_wdata_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  sgm_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom_q),
    .pix_i       (pix_i),
    .q_free_i    (q_free),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sgm_queue #(
    .Width (EntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .not_empty_o (q_not_empty),
    .free_o      (q_free)
  );

  sgm_back #(
    .MaxWidth (MAX_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .res_o         (res_o)
  );

endmodule
